// File: rtl/bdr_pkg.sv
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared types, constants and the digit table for the barcode digit reader.
// ----------------------------------------------------------------------------
package bdr_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 32;

    // Port widths
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int S_TDATA_W  = 40;   // level, position, zero fill
    localparam int M_TDATA_W  = 16;   // busy_res, code_valid, code, zero fill

    // Register word index (paddr[2])
    localparam logic REG_DOUBLE_MODE = 1'b0;

    // Request kinds carried on s_axis_tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ARM    = 1'b1;

    // Edge and sample counts
    localparam logic [3:0] HEADER_EDGES = 4'd3;
    localparam logic [3:0] GUARD_EDGES  = 4'd4;
    localparam logic [3:0] ELEM_SAMPLES = 4'd8;

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_SEARCH_HEADER = 3'd1,
        PH_PROC_HEADER   = 3'd2,
        PH_SEARCH_GUARD  = 3'd3,
        PH_PROC_GUARD    = 3'd4,
        PH_ELEM_A        = 3'd5,
        PH_ELEM_C        = 3'd6
    } t_phase;

    typedef struct packed {
        logic [6:0] code;
        logic       valid;
        logic       busy;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [3:0] digit;
    } t_digit;

    localparam logic [6:0] CODE_L [10] = '{7'h0d, 7'h19, 7'h13, 7'h3d, 7'h23,
                                          7'h31, 7'h2f, 7'h3b, 7'h37, 7'h0b};
    localparam logic [6:0] CODE_R [10] = '{7'h72, 7'h66, 7'h6c, 7'h42, 7'h5c,
                                          7'h4e, 7'h50, 7'h44, 7'h48, 7'h74};
    localparam logic [6:0] CODE_G [10] = '{7'h27, 7'h33, 7'h1b, 7'h21, 7'h1d,
                                          7'h39, 7'h05, 7'h11, 7'h09, 7'h17};

    // Lowest matching digit wins
    function automatic t_digit lookup_digit(logic [6:0] e);
        t_digit d;
        d = '0;
        for (int i = 9; i >= 0; i--) begin
            if (CODE_L[i] == e || CODE_G[i] == e || CODE_R[i] == e) begin
                d.hit   = 1'b1;
                d.digit = 4'(i);
            end
        end
        return d;
    endfunction

endpackage

// File: rtl/bdr_div3.sv
// ----------------------------------------------------------------------------
// bdr_div3
// Signed divide by three, truncating toward zero, by reciprocal multiplication.
// ----------------------------------------------------------------------------
module bdr_div3 #(
    parameter int POSITION_WIDTH = bdr_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic signed [POSITION_WIDTH-1:0] i_span,
    output logic signed [POSITION_WIDTH-1:0] o_quot
);
    localparam int W = POSITION_WIDTH;
    // ceil(2^(W+1)/3) gives the exact quotient for every magnitude up to 2^(W-1)
    localparam logic [W+1:0] TWO_POW = (W+2)'(1) << (W+1);
    localparam logic [W-1:0] RECIP   = W'((TWO_POW + (W+2)'(2)) / (W+2)'(3));

    logic [W-1:0]   w_mag;
    logic [2*W-1:0] w_prod;
    logic [W-1:0]   w_quot;

    assign w_mag  = i_span[W-1] ? W'(-i_span) : W'(i_span);
    assign w_prod = (2*W)'(w_mag) * (2*W)'(RECIP);
    assign w_quot = {1'b0, w_prod[2*W-1:W+1]};
    assign o_quot = i_span[W-1] ? W'(-w_quot) : w_quot;

endmodule

// File: rtl/barcode_digit_reader.sv
// ----------------------------------------------------------------------------
// barcode_digit_reader
// Arms on request, finds a start header or guard, measures the module width
// and samples seven-bit elements; reports busy and the decoded digit code.
// ----------------------------------------------------------------------------
// Results are registered in the output stage, or in the skid stage on a stall.
// Throughput: one request per cycle; s_axis_tready drops only while a stalled
// result and the request behind it are both held in the output stages.
// Reset: synchronous, active low; phase idle, all state cleared, no result held.
module barcode_digit_reader #(
    parameter int POSITION_WIDTH = bdr_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bdr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bdr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bdr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // requests
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bdr_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [0] level, [32:1] position
    input  logic                            s_axis_tuser,  // [0] op
    // results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bdr_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [0] busy_res, [1] code_valid,
                                                           // [8:2] code
);
    import bdr_pkg::*;

    localparam int W = POSITION_WIDTH;

    logic                r_double_mode;
    t_phase              r_phase, n_phase;
    logic                r_last, n_last;
    logic [3:0]          r_cnt, n_cnt;
    logic [6:0]          r_first, n_first;
    logic [6:0]          r_second, n_second;
    logic signed [W-1:0] r_span_start, n_span_start;
    logic signed [W-1:0] r_mw, n_mw;
    logic signed [W-1:0] r_nsa, n_nsa;

    logic                w_in_fire, w_out_fire, w_cfg_wr;
    logic                w_level;
    logic signed [W-1:0] w_pos, w_span, w_guard_mw, w_quot;

    t_result             n_res, r_out, r_skid;
    logic                r_out_valid, r_skid_valid;
    t_digit              w_d1, w_d2;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign prdata   = (paddr[APB_ADDR_W-1] == REG_DOUBLE_MODE) ?
                      {{(APB_DATA_W-1){1'b0}}, r_double_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_double_mode <= 1'b0;
        end else if (w_cfg_wr && paddr[APB_ADDR_W-1] == REG_DOUBLE_MODE) begin
            r_double_mode <= pwdata[0];
        end
    end

    // ---------------- handshake ----------------
    assign s_axis_tready = !r_skid_valid;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = r_out_valid && m_axis_tready;

    assign w_level    = s_axis_tdata[0];
    assign w_pos      = W'(signed'(s_axis_tdata[32:1]));
    assign w_span     = w_pos - r_span_start;
    assign w_guard_mw = w_span >>> 2;

    bdr_div3 #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_div (
        .i_span (w_span),
        .o_quot (w_quot)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_phase      = r_phase;
        n_last       = r_last;
        n_cnt        = r_cnt;
        n_first      = r_first;
        n_second     = r_second;
        n_span_start = r_span_start;
        n_mw         = r_mw;
        n_nsa        = r_nsa;

        if (w_in_fire) begin
            if (s_axis_tuser == OP_ARM) begin
                n_phase  = PH_SEARCH_HEADER;
                n_first  = '0;
                n_second = '0;
            end else begin
                case (r_phase)
                    PH_SEARCH_HEADER, PH_SEARCH_GUARD: begin
                        if (w_level) begin
                            n_span_start = w_pos;
                            n_last       = 1'b1;
                            if (r_phase == PH_SEARCH_HEADER) begin
                                n_cnt   = HEADER_EDGES;
                                n_phase = PH_PROC_HEADER;
                            end else begin
                                n_cnt   = GUARD_EDGES;
                                n_phase = PH_PROC_GUARD;
                            end
                        end
                    end
                    PH_PROC_HEADER, PH_PROC_GUARD: begin
                        if (w_level != r_last) begin
                            n_last = w_level;
                            n_cnt  = r_cnt - 4'd1;
                            if (n_cnt == 4'd0) begin
                                n_cnt = ELEM_SAMPLES;
                                if (r_phase == PH_PROC_HEADER) begin
                                    n_mw    = w_quot;
                                    n_nsa   = w_pos + (w_quot >>> 1);
                                    n_phase = PH_ELEM_A;
                                end else begin
                                    n_mw    = w_guard_mw;
                                    n_nsa   = w_pos + (w_guard_mw >>> 1);
                                    n_phase = PH_ELEM_C;
                                end
                            end
                        end
                    end
                    PH_ELEM_A, PH_ELEM_C: begin
                        if (w_pos >= r_nsa) begin
                            n_nsa = r_nsa + r_mw;
                            n_cnt = r_cnt - 4'd1;
                            if (n_cnt == 4'd0) begin
                                if (!r_double_mode || r_phase == PH_ELEM_C) begin
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_phase = PH_SEARCH_GUARD;
                                end
                            end else if (r_phase == PH_ELEM_A) begin
                                n_first = {r_first[5:0], w_level};
                            end else begin
                                n_second = {r_second[5:0], w_level};
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------- result ----------------
    assign w_d1 = lookup_digit(n_first);
    assign w_d2 = lookup_digit(n_second);

    always_comb begin
        n_res = '0;
        case (n_phase)
            PH_IDLE: begin
                if (w_d1.hit) begin
                    n_res.valid = 1'b1;
                    if (r_double_mode && w_d2.hit) begin
                        n_res.code = 7'({3'b000, w_d1.digit} * 7'd10) + {3'b000, w_d2.digit};
                    end else begin
                        n_res.code = {3'b000, w_d1.digit};
                    end
                end
            end
            PH_SEARCH_HEADER, PH_PROC_HEADER, PH_SEARCH_GUARD,
            PH_PROC_GUARD, PH_ELEM_A, PH_ELEM_C: begin
                n_res.busy = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_last       <= 1'b0;
            r_cnt        <= '0;
            r_first      <= '0;
            r_second     <= '0;
            r_span_start <= '0;
            r_mw         <= '0;
            r_nsa        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_last       <= n_last;
            r_cnt        <= n_cnt;
            r_first      <= n_first;
            r_second     <= n_second;
            r_span_start <= n_span_start;
            r_mw         <= n_mw;
            r_nsa        <= n_nsa;
        end
    end

    // Output register plus skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_fire;
            end
        end else if (w_in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_fire) begin
                r_out <= n_res;
            end
        end else if (w_in_fire) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out);

endmodule

// File: rtl/bdr_checker.sv
// ----------------------------------------------------------------------------
// bdr_checker
// Port-level checks for the barcode digit reader, bound to the top level.
// ----------------------------------------------------------------------------
module bdr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bdr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import bdr_pkg::*;

    // Reset drops any held result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Every accepted request leaves a result pending
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    // A valid code only when idle, and in range
    a_code_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0] && m_axis_tdata[8:2] <= 7'd99)
        else $error("code valid while busy or out of range");

endmodule

bind barcode_digit_reader bdr_checker u_bdr_checker (.*);

// File: test/barcode_digit_reader_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barcode_digit_reader_checker
// Watches the configuration port and both streams of the digit reader, keeps
// its own model of the acquisition state, and compares every result with the
// oldest predicted reading.
// ----------------------------------------------------------------------------
module barcode_digit_reader_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [bdr_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [bdr_pkg::APB_DATA_W-1:0]  i_pwdata,
    input  logic [bdr_pkg::APB_DATA_W-1:0]  i_prdata,
    input  logic                            i_pready,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [bdr_pkg::S_TDATA_W-1:0]   i_req_data,   // [0] level, [32:1] position
    input  logic                            i_req_user,   // [0] op
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [bdr_pkg::M_TDATA_W-1:0]   i_res_data,   // [0] busy_res, [1] code_valid,
                                                          // [8:2] code
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_codes
);

    import bdr_pkg::*;

    localparam logic [3:0] HEADER_CHANGES = 4'd3;
    localparam logic [3:0] GUARD_CHANGES  = 4'd4;
    localparam logic [3:0] BITS_PER_ELEM  = 4'd8;

    localparam logic [6:0] L_SET [10] = '{7'h0d, 7'h19, 7'h13, 7'h3d, 7'h23,
                                         7'h31, 7'h2f, 7'h3b, 7'h37, 7'h0b};
    localparam logic [6:0] G_SET [10] = '{7'h27, 7'h33, 7'h1b, 7'h21, 7'h1d,
                                         7'h39, 7'h05, 7'h11, 7'h09, 7'h17};
    localparam logic [6:0] R_SET [10] = '{7'h72, 7'h66, 7'h6c, 7'h42, 7'h5c,
                                         7'h4e, 7'h50, 7'h44, 7'h48, 7'h74};

    logic               double_mode;
    t_phase             phase;
    logic               last_level;
    logic [3:0]         countdown;
    logic [6:0]         first_elem;
    logic [6:0]         second_elem;
    logic signed [31:0] span_start;
    logic signed [31:0] module_width;
    logic signed [31:0] next_sample_at;

    t_result            pending_readings[$];

    function automatic int digit_of(logic [6:0] e);
        for (int i = 0; i < 10; i++) begin
            if (L_SET[i] == e || G_SET[i] == e || R_SET[i] == e) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Advance the acquisition by one request and form the reading it leaves
    function automatic t_result reader_step(logic op, logic lv, logic signed [31:0] pos);
        t_result            r;
        logic signed [31:0] span;
        int                 d1;
        int                 d2;
        r = '0;
        if (op == OP_ARM) begin
            phase       = PH_SEARCH_HEADER;
            first_elem  = '0;
            second_elem = '0;
        end else begin
            case (phase)
                PH_SEARCH_HEADER, PH_SEARCH_GUARD: begin
                    if (lv) begin
                        span_start = pos;
                        last_level = 1'b1;
                        if (phase == PH_SEARCH_HEADER) begin
                            countdown = HEADER_CHANGES;
                            phase     = PH_PROC_HEADER;
                        end else begin
                            countdown = GUARD_CHANGES;
                            phase     = PH_PROC_GUARD;
                        end
                    end
                end
                PH_PROC_HEADER, PH_PROC_GUARD: begin
                    if (lv != last_level) begin
                        last_level = lv;
                        countdown  = countdown - 4'd1;
                        if (countdown == 4'd0) begin
                            span = pos - span_start;
                            if (phase == PH_PROC_HEADER) begin
                                module_width = span / 3;
                                phase        = PH_ELEM_A;
                            end else begin
                                module_width = span >>> 2;
                                phase        = PH_ELEM_C;
                            end
                            next_sample_at = pos + (module_width >>> 1);
                            countdown      = BITS_PER_ELEM;
                        end
                    end
                end
                PH_ELEM_A, PH_ELEM_C: begin
                    if (pos >= next_sample_at) begin
                        next_sample_at = next_sample_at + module_width;
                        countdown      = countdown - 4'd1;
                        if (countdown == 4'd0) begin
                            if (!double_mode || phase == PH_ELEM_C) begin
                                phase = PH_IDLE;
                            end else begin
                                phase = PH_SEARCH_GUARD;
                            end
                        end else if (phase == PH_ELEM_A) begin
                            first_elem = {first_elem[5:0], lv};
                        end else begin
                            second_elem = {second_elem[5:0], lv};
                        end
                    end
                end
                default: ;
            endcase
        end
        r.busy = (phase >= PH_SEARCH_HEADER && phase <= PH_ELEM_C);
        if (!r.busy) begin
            d1 = digit_of(first_elem);
            if (d1 >= 0) begin
                r.valid = 1'b1;
                r.code  = 7'(d1);
                if (double_mode) begin
                    d2 = digit_of(second_elem);
                    if (d2 >= 0) begin
                        r.code = 7'(d1 * 10 + d2);
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            double_mode    = 1'b0;
            phase          = PH_IDLE;
            last_level     = 1'b0;
            countdown      = '0;
            first_elem     = '0;
            second_elem    = '0;
            span_start     = '0;
            module_width   = '0;
            next_sample_at = '0;
            pending_readings.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_DOUBLE_MODE) begin
                if (i_pwrite) begin
                    double_mode = i_pwdata[0];
                end else if (i_prdata !== {31'd0, double_mode}) begin
                    $error("double_mode readback: expected %0h, actual %0h",
                           {31'd0, double_mode}, i_prdata);
                    o_errors++;
                end
            end
            // Results leave from the output register, so drain before predicting
            if (i_res_valid && i_res_ready) begin
                got = t_result'(i_res_data[8:0]);
                o_results++;
                if (pending_readings.size() == 0) begin
                    $error("result with no request outstanding: tdata %h", i_res_data);
                    o_errors++;
                end else begin
                    want = pending_readings.pop_front();
                    if (got.valid === 1'b1) begin
                        o_codes++;
                    end
                    if (got.busy !== want.busy) begin
                        $error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
                        o_errors++;
                    end
                    if (got.valid !== want.valid) begin
                        $error("code_valid: expected %0d, actual %0d", want.valid, got.valid);
                        o_errors++;
                    end
                    if (got.code !== want.code) begin
                        $error("code: expected %0d, actual %0d", want.code, got.code);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                pending_readings.push_back(reader_step(i_req_user, i_req_data[0],
                                                       $signed(i_req_data[32:1])));
            end
        end
        o_pending = pending_readings.size();
    end

endmodule

// File: test/barcode_digit_reader_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barcode_digit_reader_test
// Drives arm requests and sensor samples into the digit reader: a few fixed
// readings around the position wrap, then random barcode scans with header,
// element bits and guard, broken scans and noise, in both digit modes and
// under several idling patterns. The checker judges every result.
// ----------------------------------------------------------------------------
module barcode_digit_reader_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEGMENT_ITEMS = 215;
    localparam int NO_LIMIT      = 1 << 30;
    localparam int HOLD_CYCLES   = 80;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bdr_pkg::APB_ADDR_W-1:0]  paddr;
    logic [bdr_pkg::APB_DATA_W-1:0]  pwdata;
    logic [bdr_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [bdr_pkg::S_TDATA_W-1:0]   s_axis_tdata;   // [0] level, [32:1] position
    logic                            s_axis_tuser;   // [0] op
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [bdr_pkg::M_TDATA_W-1:0]   m_axis_tdata;   // [0] busy_res, [1] code_valid,
                                                     // [8:2] code

    int          errors;
    int          pending;
    int          results;
    int          codes;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          n_sent;
    int          budget;
    int          cycle_count;
    logic [31:0] cursor;
    logic        cur_mode;
    bit          hold_off_go;
    bit          hold_off_done;

    barcode_digit_reader u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    barcode_digit_reader_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_codes     (codes)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** barcode_digit_reader: FAILED **");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_go && !hold_off_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send(logic op, logic lv, logic [31:0] pos);
        if (budget <= 0) begin
            return;
        end
        budget--;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, pos, lv};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic apb_access(logic wr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {bdr_pkg::REG_DOUBLE_MODE, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain all readings, let the block settle, then switch the digit mode
    task automatic apply_mode(logic mode);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        apb_access(1'b1, {31'd0, mode});
        @(negedge i_clk);
        apb_access(1'b0, '0);
        cur_mode = mode;
    endtask

    // Alternating levels, a bar first, one module apart; p ends on the last change
    task automatic send_edges(inout logic [31:0] p, input int unsigned w, input int n,
                              input bit rough);
        for (int i = 0; i < n; i++) begin
            send(bdr_pkg::OP_SAMPLE, ~i[0], p + i * w);
            if (rough && $urandom_range(3) == 0) begin
                send(bdr_pkg::OP_SAMPLE, ~i[0], p + i * w);
            end
        end
        p = p + (n - 1) * w;
    endtask

    // Seven element bits at mid-module points, then the closing sample
    task automatic send_element(inout logic [31:0] p, input int unsigned w,
                                input logic [6:0] e, input bit rough);
        logic [31:0] thr;
        logic        lv;
        thr = p + (w >> 1);
        for (int k = 0; k < 8; k++) begin
            if (rough && w > 1 && $urandom_range(2) == 0) begin
                send(bdr_pkg::OP_SAMPLE, 1'($urandom_range(1)), thr - 1);
            end
            lv = (k < 7) ? e[6 - k] : 1'($urandom_range(1));
            send(bdr_pkg::OP_SAMPLE, lv, thr + (rough ? $urandom_range(w - 1) : 0));
            thr = thr + w;
        end
        p = thr;
    endtask

    task automatic send_read(logic [6:0] elem_a, logic [6:0] elem_c, int unsigned w,
                             bit with_guard, bit rough);
        logic [31:0] p;
        p = cursor;
        send(bdr_pkg::OP_ARM, 1'($urandom_range(1)), $urandom);
        if (rough) begin
            repeat ($urandom_range(2)) send(bdr_pkg::OP_SAMPLE, 1'b0, p - 1);
        end
        send_edges(p, w, 4, rough);
        send_element(p, w, elem_a, rough);
        if (with_guard) begin
            p = p + $urandom_range(w);
            if (rough) begin
                send(bdr_pkg::OP_SAMPLE, 1'b0, p);
            end
            send_edges(p, w, 5, rough);
            send_element(p, w, elem_c, rough);
        end
        cursor = p + $urandom_range(1000);
    endtask

    function automatic logic [6:0] pick_element();
        int d;
        d = $urandom_range(9);
        case ($urandom_range(3))
            0:       return bdr_pkg::CODE_L[d];
            1:       return bdr_pkg::CODE_G[d];
            2:       return bdr_pkg::CODE_R[d];
            default: return 7'($urandom_range(127));
        endcase
    endfunction

    task automatic random_step();
        int          r;
        int          wr;
        int unsigned w;
        bit          guard;
        r  = $urandom_range(99);
        wr = $urandom_range(99);
        if (wr < 80) begin
            w = $urandom_range(40, 1);
        end else if (wr < 95) begin
            w = $urandom_range(5000, 41);
        end else begin
            w = $urandom_range(1 << 24, 5001);
        end
        guard = cur_mode ? ($urandom_range(9) != 0) : ($urandom_range(4) == 0);
        if ($urandom_range(9) == 0) begin
            cursor = $urandom;
        end
        if (r < 70) begin
            send_read(pick_element(), pick_element(), w, guard, 1'($urandom_range(1)));
        end else if (r < 85) begin
            // cut the scan short somewhere
            budget = $urandom_range(14, 2);
            send_read(pick_element(), pick_element(), w, guard, 1'($urandom_range(1)));
            budget = NO_LIMIT;
        end else begin
            send(bdr_pkg::OP_ARM, 1'($urandom_range(1)), $urandom);
            repeat ($urandom_range(15, 3)) begin
                send(($urandom_range(19) == 0) ? bdr_pkg::OP_ARM : bdr_pkg::OP_SAMPLE,
                     1'($urandom_range(1)),
                     $urandom_range(1) ? $urandom : cursor + $urandom_range(200));
            end
        end
    endtask

    initial begin
        int target;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = bdr_pkg::OP_SAMPLE;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        budget        = NO_LIMIT;
        cursor        = '0;
        cur_mode      = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apply_mode(1'b0);
        // Samples while idle leave the acquisition state unchanged
        send(bdr_pkg::OP_SAMPLE, 1'b1, 32'h7fff_ffff);
        send(bdr_pkg::OP_SAMPLE, 1'b0, 32'h8000_0000);
        // Header just below the positive limit; sample points wrap negative
        send(bdr_pkg::OP_ARM, 1'b1, 32'hffff_ffff);
        send(bdr_pkg::OP_SAMPLE, 1'b1, 32'h7fff_fff0);
        send(bdr_pkg::OP_SAMPLE, 1'b0, 32'h7fff_fff4);
        send(bdr_pkg::OP_SAMPLE, 1'b1, 32'h7fff_fff8);
        send(bdr_pkg::OP_SAMPLE, 1'b0, 32'h7fff_fffc);
        send(bdr_pkg::OP_SAMPLE, 1'b1, 32'h7fff_ffff);
        send(bdr_pkg::OP_SAMPLE, 1'b0, 32'h8000_0001);
        send(bdr_pkg::OP_SAMPLE, 1'b1, 32'h8000_0003);
        // Clean reading starting at the most negative position, rearmed mid-scan
        cursor = 32'h8000_0000;
        send_read(bdr_pkg::CODE_R[0], bdr_pkg::CODE_L[9], 3, 1'b0, 1'b0);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 25; recv_idle_pct = 54; end
                1: begin send_idle_pct = 54; recv_idle_pct = 25; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int half = 0; half < 2; half++) begin
                apply_mode(half == 0);
                if (ph == 2 && half == 0) begin
                    hold_off_go = 1'b1;
                end
                target = n_sent + SEGMENT_ITEMS;
                while (n_sent < target) random_step();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        $display("Run covered %0d requests and %0d checked results, %0d with a decoded digit,",
                 n_sent, results, codes);
        $display("in single and double digit mode under three idling patterns and a hold-off.");
        if (errors == 0) begin
            $display("** barcode_digit_reader: PASSED **");
        end else begin
            $display("** barcode_digit_reader: FAILED **");
        end
        $finish;
    end

endmodule
